// ----- rtl/fwrv_pkg.sv -----
package fwrv_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUMP     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // per-cell control
  typedef struct packed {
    logic cap;  // capture key compare
    logic wr;   // load broadcast value
    logic shl;  // take neighbor's value
  } cell_ctl_t;

endpackage

// ----- rtl/fwrv_cell.sv -----
module fwrv_cell
  import fwrv_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] key,
  input  logic [DATA_W-1:0] bcast,
  input  logic [DATA_W-1:0] nxt,
  output logic [DATA_W-1:0] data,
  output logic              hit
);

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      data <= bcast;
    end else if (ctl.shl) begin
      data <= nxt;
    end
    if (ctl.cap) begin
      hit <= (data == key);
    end
  end

endmodule

// ----- rtl/fifo_with_remove_by_value_core.sv -----
// Ordered queue of up to DEPTH signed 32-bit values with delete by key.
// Input channel s_*: s_tuser = opcode (0 push, 1 remove first match,
// 2 dump), s_tdata = value. Output channel m_*: m_tdata = entry,
// m_tuser = {is_empty, status}, m_tlast = last result of the item.
// The queue is a row of cells, one entry each, head in cell 0.
// Push and remove take an accept cycle, in which every cell compares its
// entry with the key, and an execute cycle, in which the tail cell loads or
// the first match and the cells behind it shift up one place.
// A dump rotates the row by one cell per cycle while the output register is
// free, the head going out and back in at the tail, so after N results for
// N entries the queue is as before. An empty dump gives one result.
// Results are registered and appear on m_* in the cycle after the execute
// cycle. The output register lets a new item be accepted while a result
// waits; when m_tready is low, the execute and dump steps wait for the register to free up.
// Opcode 3 is accepted and dropped with no result.
// Reset empties the queue and the output register; entry cells are not
// cleared.
module fifo_with_remove_by_value_core
  import fwrv_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [1:0]        s_tuser,   // [1:0] opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] entry
  output logic [3:0]        m_tuser,   // [2:0] status, [3] is_empty
  output logic              m_tlast
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int LVL   = $clog2(DEPTH);
  localparam logic [OCC_W-1:0] FULL = OCC_W'(DEPTH);

  state_t           state, state_next;
  op_t              op;
  logic [OCC_W-1:0] occ, occ_next;
  logic [OCC_W-1:0] cnt, cnt_next;
  logic [OCC_W-1:0] occ_m1;

  logic [DATA_W-1:0] data [DEPTH];
  logic [DEPTH-1:0]  hit;
  logic [DEPTH-1:0]  hv;
  logic [DEPTH-1:0]  pre [LVL+1];
  cell_ctl_t         ctl [DEPTH];
  logic [DATA_W-1:0] bcast;
  logic              found;
  logic [DATA_W-1:0] s_tdata_q;

  logic              out_free;
  logic              emit;
  status_t           e_status;
  logic [DATA_W-1:0] e_entry;
  logic              e_empty;
  logic              e_last;
  logic              cap, do_push, do_rem, do_rot;

  assign occ_m1   = occ - OCC_W'(1);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign bcast    = do_rot ? data[0] : s_tdata_q;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = data[i+1];
    end
    assign hv[i]      = hit[i] && (OCC_W'(i) < occ);
    assign ctl[i].cap = cap;
    assign ctl[i].wr  = (do_push && (OCC_W'(i) == occ)) ||
                        (do_rot && (OCC_W'(i) == occ_m1));
    assign ctl[i].shl = (do_rem && pre[LVL][i]) || do_rot;

    fwrv_cell u_cell (
      .clk  (clk),
      .ctl  (ctl[i]),
      .key  (s_tdata),
      .bcast(bcast),
      .nxt  (nxt),
      .data (data[i]),
      .hit  (hit[i])
    );
  end

  // prefix OR of hits: cells at and behind the first match shift up
  assign pre[0] = hv;
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar i = 0; i < DEPTH; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][i] = pre[l][i];
      end
    end
  end
  assign found = pre[LVL][DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op        <= op_t'(s_tuser);
      s_tdata_q <= s_tdata;
    end
  end

  always_comb begin
    state_next = state;
    occ_next   = occ;
    cnt_next   = cnt;
    emit       = 1'b0;
    e_status   = ST_PUSHED;
    e_entry    = '0;
    e_empty    = 1'b0;
    e_last     = 1'b1;
    cap        = 1'b0;
    do_push    = 1'b0;
    do_rem     = 1'b0;
    do_rot     = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cap = 1'b1;
          case (s_tuser)
            OP_PUSH, OP_REMOVE, OP_DUMP: state_next = S_EXEC;
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (op)
            OP_PUSH: begin
              if (occ == FULL) begin
                e_status = ST_FULL;
              end else begin
                do_push  = 1'b1;
                occ_next = occ + OCC_W'(1);
              end
            end
            OP_REMOVE: begin
              if (found) begin
                do_rem   = 1'b1;
                occ_next = occ_m1;
                e_status = ST_REMOVED;
              end else begin
                e_status = ST_NOTFOUND;
              end
            end
            OP_DUMP: begin
              e_status = ST_DUMP;
              if (occ == '0) begin
                e_empty = 1'b1;
              end else begin
                e_entry = data[0];
                do_rot  = 1'b1;
                e_last  = (occ == OCC_W'(1));
                if (!e_last) begin
                  state_next = S_DUMP;
                  cnt_next   = OCC_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = ST_DUMP;
          e_entry  = data[0];
          do_rot   = 1'b1;
          e_last   = (cnt == occ_m1);
          if (e_last) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + OCC_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= e_entry;
      m_tuser <= {e_empty, e_status};
      m_tlast <= e_last;
    end
  end

endmodule

// ----- rtl/fwrv_checker.sv -----
module fwrv_checker
  import fwrv_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [1:0]        s_tuser,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [3:0]        m_tuser,
  input logic              m_tlast
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // an accepted command other than opcode 3 blocks the input in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != 2'd3) |=> !s_tready)
    else $error("input accepted during command execution");

  // push and remove give one single result with zero entry
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != ST_DUMP) |-> m_tlast && (m_tdata == '0) && !m_tuser[3])
    else $error("non-dump result malformed");

  // empty dump result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tlast && (m_tdata == '0) && (m_tuser[2:0] == ST_DUMP))
    else $error("empty dump result malformed");

  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

endmodule

bind fifo_with_remove_by_value_core fwrv_checker u_fwrv_checker (.*);

// ----- bench/tb_fifo_with_remove_by_value_core.sv -----
module tb_fifo_with_remove_by_value_core;
  import fwrv_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 400;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS = 20;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] value;
    int          gap;
  } queue_cmd_t;

  typedef struct {
    status_t     status;
    logic [31:0] entry;
    logic        is_empty;
    logic        last;
  } queue_resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [31:0] value
  logic [1:0]        s_tuser = '0;   // [1:0] opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [31:0] entry
  logic [3:0]        m_tuser;        // [2:0] status, [3] is_empty
  logic              m_tlast;

  queue_cmd_t  pending_cmds[$];
  queue_resp_t expected_resps[$];
  logic [31:0] queue_image[$];       // predicted contents, head first
  logic [31:0] key_pool[8];

  int errors, n_items, n_resps, idle_cycles;
  int n_push, n_full, n_remove, n_miss, n_dump, n_empty_dump, peak_occ;
  int tx_hold, rx_hold;
  bit tx_calm, rx_calm;

  fifo_with_remove_by_value_core #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %h, want %h (result %0d)",
               $time, what, got, want, n_resps);
    end
  endtask

  task automatic add_cmd(logic [1:0] op, logic [31:0] value);
    queue_cmd_t c;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    c.op    = op;
    c.value = value;
    c.gap   = tx_calm ? 0 : $urandom_range(0, 9);
    pending_cmds.push_back(c);
  endtask

  // updates the queue image and lines up the responses for one command
  function automatic void predict_queue_op(logic [1:0] op, logic [31:0] value);
    queue_resp_t r;
    int hit;
    r.status   = ST_PUSHED;
    r.entry    = '0;
    r.is_empty = 1'b0;
    r.last     = 1'b1;
    hit        = -1;
    case (op)
      OP_PUSH: begin
        n_push++;
        if (queue_image.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          queue_image.push_back(value);
        end
        expected_resps.push_back(r);
      end
      OP_REMOVE: begin
        n_remove++;
        foreach (queue_image[i]) begin
          if (hit < 0 && queue_image[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
          n_miss++;
        end else begin
          r.status = ST_REMOVED;
          queue_image.delete(hit);
        end
        expected_resps.push_back(r);
      end
      OP_DUMP: begin
        n_dump++;
        r.status = ST_DUMP;
        if (queue_image.size() == 0) begin
          r.is_empty = 1'b1;
          n_empty_dump++;
          expected_resps.push_back(r);
        end else begin
          foreach (queue_image[i]) begin
            r.entry = queue_image[i];
            r.last  = (i == queue_image.size() - 1);
            expected_resps.push_back(r);
          end
        end
      end
      default: ;
    endcase
    if (queue_image.size() > peak_occ) peak_occ = queue_image.size();
  endfunction

  always @(posedge clk) begin : cmd_driver
    queue_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_queue_op(s_tuser, s_tdata);
        n_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_hold > 0) begin
          s_tvalid <= 1'b0;
          tx_hold  <= tx_hold - 1;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.value;
          s_tuser  <= nxt.op;
          tx_hold  <= nxt.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : resp_monitor
    queue_resp_t want;
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else begin
      stall = rx_hold;
      if (m_tvalid && m_tready) begin
        n_resps++;
        if (expected_resps.size() == 0) begin
          report("unexpected result", {m_tlast, m_tuser, m_tdata}, '0);
        end else begin
          want = expected_resps.pop_front();
          if (m_tuser[2:0] !== want.status) report("status", m_tuser[2:0], want.status);
          if (m_tdata !== want.entry) report("entry", m_tdata, want.entry);
          if (m_tuser[3] !== want.is_empty) report("is_empty", m_tuser[3], want.is_empty);
          if (m_tlast !== want.last) report("last", m_tlast, want.last);
        end
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        stall = rx_calm ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        rx_hold  <= stall - 1;
      end else begin
        m_tready <= 1'b1;
        rx_hold  <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("no item moved for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int mode, r, n_random, p_push, p_rem, p_dump;
    logic [1:0] op;
    logic [31:0] v;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom();

    // empty queue, extremes, duplicates, head/middle/tail removal, misses
    add_cmd(OP_DUMP, $urandom());
    add_cmd(OP_REMOVE, 32'h0000_0000);
    add_cmd(OP_PUSH, 32'h8000_0000);
    add_cmd(OP_PUSH, 32'h7fff_ffff);
    add_cmd(OP_PUSH, 32'h0000_0000);
    add_cmd(OP_PUSH, 32'hffff_ffff);
    add_cmd(OP_PUSH, 32'h7fff_ffff);
    add_cmd(OP_DUMP, 32'h0000_0000);
    add_cmd(OP_REMOVE, 32'h7fff_ffff);
    add_cmd(OP_REMOVE, 32'h1234_5678);
    add_cmd(OP_UNUSED, 32'hffff_ffff);
    add_cmd(OP_DUMP, 32'hffff_ffff);
    add_cmd(OP_REMOVE, 32'h7fff_ffff);
    add_cmd(OP_REMOVE, 32'h8000_0000);
    add_cmd(OP_DUMP, $urandom());
    add_cmd(OP_REMOVE, 32'h0000_0000);
    add_cmd(OP_REMOVE, 32'hffff_ffff);
    add_cmd(OP_DUMP, 32'h0000_0000);

    // phases: fill toward full, drain by key, mixed
    n_random = 0;
    while (n_random < N_RANDOM) begin
      mode = $urandom_range(0, 2);
      case (mode)
        0: begin p_push = 85; p_rem = 92; p_dump = 98; end
        1: begin p_push = 20; p_rem = 88; p_dump = 97; end
        default: begin p_push = 45; p_rem = 80; p_dump = 97; end
      endcase
      repeat ($urandom_range(10, 50)) begin
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom();
        if (r < p_push) op = OP_PUSH;
        else if (r < p_rem) op = OP_REMOVE;
        else if (r < p_dump) op = OP_DUMP;
        else op = OP_UNUSED;
        add_cmd(op, v);
        if (op != OP_UNUSED) n_random++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || s_tvalid || expected_resps.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_resps.size() != 0) report("results never seen", expected_resps.size(), 0);

    $display("ran %0d commands: %0d pushes (%0d dropped on full), %0d removes (%0d misses)",
             n_items, n_push, n_full, n_remove, n_miss);
    $display("%0d dumps (%0d of an empty queue), %0d results checked, peak occupancy %0d",
             n_dump, n_empty_dump, n_resps, peak_occ);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
